// ----- sv/tcw_pkg.sv -----
// Package for the text console writer: command and result item types,
// command kind codes and character constants. No dependencies.
package tcw_pkg;

  // Field widths of the command and result items.
  localparam int KIND_W   = 2;
  localparam int CODE_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int OFFSET_W = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  // Command kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_MOVE  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Character codes with special handling.
  localparam logic [CODE_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] PRINT_LAST = 8'h7F;

  // Attribute and blank cell after reset.
  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = {RESET_ATTR, CHAR_SPACE};

  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] char_code;
    logic [COL_W-1:0]  target_column;
    logic [ROW_W-1:0]  target_row;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]    cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic [OFFSET_W-1:0] cursor_offset;
    logic [CELL_W-1:0]   cell_value;
  } rsp_t;

endpackage

// ----- sv/text_console_writer.sv -----
// Text console writer: screen store of character/attribute cells and a cursor,
// driven by put-character, clear, move-cursor and read-cell commands.
// Depends on tcw_pkg.
//
// Usage:
//   A command item is taken on a rising edge with start high and busy low.
//   Each item yields one result: done is high for exactly one cycle while
//   result holds the cursor, its linear offset and, for a read, the cell.
//   The receiver cannot stall; results are simply presented.
//   Timing by command:
//     put character (no scroll), move cursor: result in the cycle after accept,
//       busy stays low, so one item per cycle.
//     read cell: one memory read, registered, then moved into the result in S_READ.
//     clear screen: S_FILL writes one blank cell per cycle over the store, then the result.
//     put character that scrolls: S_SCROLL, then S_DRAIN; the scroll copies
//       the store one cell per cycle through its single read port.
//   Reset: the cursor goes to 0,0 and the attribute to 07h; then a clearing
//     pass fills the store with blank cells while busy is high. Attribute
//     writes (cfg_we, cfg_data) are taken at any time and are meant to happen
//     while no command is in flight.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd,
  output logic              done,
  output rsp_t              result,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_data
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int LAST_ROW = (ROWS - 1) * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = (ROWS > 2) ? $clog2(ROWS) : 1;

  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_FILL,
    S_SCROLL,
    S_DRAIN
  } state_t;

  state_t              state;
  logic [AW-1:0]       cnt;
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [ATTR_W-1:0]   attr;
  logic                wr_pend;
  logic [AW-1:0]       wr_addr;
  logic                wr_blank;

  logic [CELL_W-1:0]   mem [CELLS];
  logic [CELL_W-1:0]   rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [AW-1:0]       mem_raddr;

  logic                accept;
  logic [CW-1:0]       tcol;
  logic [RW-1:0]       trow;
  logic [CW:0]         col_w;
  logic [RW:0]         row_w;
  logic [CW-1:0]       col_next;
  logic [RW-1:0]       row_next;
  logic                scroll_req;
  logic                wr_char;
  logic [AW-1:0]       cur_offset;
  logic [AW-1:0]       tgt_offset;
  logic [AW-1:0]       offset_next;
  logic [AW:0]         src;
  logic [CELL_W-1:0]   blank;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign blank  = {attr, CHAR_SPACE};

  // Clamp the target position of move and read commands.
  assign tcol = ({1'b0, cmd.target_column} > 8'(COLUMNS - 1)) ?
                CW'(COLUMNS - 1) : CW'(cmd.target_column);
  assign trow = ({2'b0, cmd.target_row} > 7'(ROWS - 1)) ?
                RW'(ROWS - 1) : RW'(cmd.target_row);

  assign cur_offset = AW'(row) * COLS_A + AW'(col);
  assign tgt_offset = AW'(trow) * COLS_A + AW'(tcol);
  assign src        = {1'b0, cnt} + (AW + 1)'(COLUMNS);

  // Cursor update for an accepted command.
  always_comb begin
    col_w      = {1'b0, col};
    row_w      = {1'b0, row};
    scroll_req = 1'b0;
    wr_char    = 1'b0;
    if (accept) begin
      unique case (cmd.kind)
        KIND_CHAR: begin
          if (cmd.char_code == CHAR_CR) begin
            col_w = '0;
          end else if (cmd.char_code == CHAR_LF) begin
            col_w = '0;
            row_w = row_w + 1'b1;
          end else if (cmd.char_code == CHAR_BS) begin
            if (col != '0) begin
              col_w = col_w - 1'b1;
            end
          end else if (cmd.char_code >= CHAR_SPACE && cmd.char_code <= PRINT_LAST) begin
            wr_char = 1'b1;
            col_w   = col_w + 1'b1;
          end
          if (col_w >= (CW + 1)'(COLUMNS)) begin
            col_w = '0;
            row_w = row_w + 1'b1;
          end
          if (row_w >= (RW + 1)'(ROWS)) begin
            scroll_req = 1'b1;
            row_w      = (RW + 1)'(ROWS - 1);
          end
        end
        KIND_CLEAR: begin
          col_w = '0;
          row_w = '0;
        end
        KIND_MOVE: begin
          col_w = {1'b0, tcol};
          row_w = {1'b0, trow};
        end
        KIND_READ: begin
          col_w = {1'b0, col};
          row_w = {1'b0, row};
        end
      endcase
    end
    col_next = col_w[CW-1:0];
    row_next = row_w[RW-1:0];
  end

  assign offset_next = AW'(row_next) * COLS_A + AW'(col_next);

  // Memory port selection: sweeps, scroll copy and character writes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = blank;
    mem_raddr = tgt_offset;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = BLANK_RESET;
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_SCROLL, S_DRAIN: begin
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
        mem_wdata = wr_blank ? blank : rd_data;
        mem_raddr = (cnt < AW'(LAST_ROW)) ? src[AW-1:0] : '0;
      end
      S_IDLE: begin
        mem_we    = wr_char;
        mem_waddr = cur_offset;
        mem_wdata = {attr, cmd.char_code};
      end
      S_READ: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Screen store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Sequencer, cursor, attribute and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cnt     <= '0;
      col     <= '0;
      row     <= '0;
      attr    <= RESET_ATTR;
      done    <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_data;
      end
      col  <= col_next;
      row  <= row_next;
      done <= 1'b0;
      result.cursor_column <= COL_W'(col_next);
      result.cursor_row    <= ROW_W'(row_next);
      result.cursor_offset <= OFFSET_W'(offset_next);
      result.cell_value    <= '0;
      unique case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(CELLS - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt     <= '0;
          wr_pend <= 1'b0;
          if (accept) begin
            if (cmd.kind == KIND_CLEAR) begin
              state <= S_FILL;
            end else if (cmd.kind == KIND_READ) begin
              state <= S_READ;
            end else if (scroll_req) begin
              state <= S_SCROLL;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_READ: begin
          result.cell_value <= rd_data;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        S_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(CELLS - 1)) begin
            cnt   <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCROLL: begin
          wr_pend  <= 1'b1;
          wr_addr  <= cnt;
          wr_blank <= (cnt >= AW'(LAST_ROW));
          cnt      <= cnt + 1'b1;
          if (cnt == AW'(CELLS - 1)) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          wr_pend <= 1'b0;
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item either finishes in the next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted item neither finished nor held the block busy");

  // The cursor always stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (col < CW'(COLUMNS - 1) || col == CW'(COLUMNS - 1)) &&
    (row < RW'(ROWS - 1) || row == RW'(ROWS - 1)))
    else $error("cursor left the screen");

  // A multi-cycle command ends with its result, except the reset clearing pass.
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && ($past(state) != S_INIT) |-> done)
    else $error("command finished without a result");

  // No result is presented during the reset clearing pass.
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !done)
    else $error("result during clearing pass");

endmodule
